[rtl/rgbhm_pkg.sv]
`timescale 1ns / 1ps
package rgbhm_pkg;
   localparam int BINS = 256;
   localparam int COUNT_BITS = 32;
   localparam int DIM_W = $clog2(BINS + 1);
   localparam int IDX_W = $clog2(BINS);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH = BINS * BINS;
   localparam int PROD_W = 2 * COUNT_BITS;

   localparam logic [1:0] KIND_LOAD_RG = 2'd0;
   localparam logic [1:0] KIND_LOAD_GB = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [1:0] REG_RG_COLUMNS = 2'd0;
   localparam logic [1:0] REG_RG_ROWS = 2'd1;
   localparam logic [1:0] REG_GB_COLUMNS = 2'd2;
   localparam logic [1:0] REG_GB_ROWS = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] table_index;
      logic [31:0] table_word;
      logic [31:0] source_count;
   } req_type;

   typedef struct packed {
      logic [7:0] red_index;
      logic [7:0] green_index;
      logic [7:0] blue_index;
      logic       divide_fault;
   } rsp_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v);
      logic [DIM_W-1:0] r;
      if (v < 9'd2) r = DIM_W'(2);
      else if (32'(v) > BINS) r = DIM_W'(BINS);
      else r = DIM_W'(v);
      return r;
   endfunction
endpackage

[rtl/rgbhm_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit a cycle
module rgbhm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rgbhm_pkg::PROD_W-1:0]        dividend,
   input  logic [rgbhm_pkg::COUNT_BITS-1:0]    divisor,
   output logic                                done,
   output logic [rgbhm_pkg::PROD_W-1:0]        quotient
);
   localparam int QW = rgbhm_pkg::PROD_W;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] quot_ff, quot_in;
   logic [rgbhm_pkg::COUNT_BITS:0] rem_ff, rem_in;
   logic [rgbhm_pkg::COUNT_BITS-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [rgbhm_pkg::COUNT_BITS:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[rgbhm_pkg::COUNT_BITS-1:0], quot_ff[QW-1]};
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;
endmodule

[rtl/rgb_cdf_histogram_match.sv]
`timescale 1ns / 1ps
// Histogram matching against two cumulative tables (red-green and green-blue), each held in
// a synchronous memory of BINS*BINS 32-bit words with one write port and one read port. A
// load beat writes one word. A query with a nonzero count reads the two table totals, then
// for each of red, green and blue reads a scale entry, rescales the count with a 64-bit
// multiply and a bit-serial divide, and walks the line one memory read a cycle; if either
// total is zero it returns zero indices with divide_fault set instead. A query with a zero
// count is taken but gives no result. A finished result waits in the output register, so
// loads keep flowing while it is held. Configuration writes are taken only while no query
// is in flight. Table contents are undefined until loaded.
module rgb_cdf_histogram_match (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rgbhm_pkg::req_type         req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rgbhm_pkg::rsp_type         rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [8:0]                 csr_data
);
   localparam int AW = rgbhm_pkg::ADDR_W;
   localparam int IW = rgbhm_pkg::IDX_W;
   localparam int DW = rgbhm_pkg::DIM_W;
   localparam int CB = rgbhm_pkg::COUNT_BITS;
   localparam int PW = rgbhm_pkg::PROD_W;

   localparam logic [1:0] PH_RED = 2'd0;
   localparam logic [1:0] PH_GREEN = 2'd1;
   localparam logic [1:0] PH_BLUE = 2'd2;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_TOT1  = 8'b00000010,
      S_TOT2  = 8'b00000100,
      S_SCALE = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_WALK  = 8'b00100000,
      S_NEXT  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   logic [CB-1:0] rg_mem [rgbhm_pkg::DEPTH];
   logic [CB-1:0] gb_mem [rgbhm_pkg::DEPTH];
   logic [CB-1:0] rg_q, gb_q, rd_q;

   state_type state_ff, state_in;
   logic [8:0] rgc_ff, rgr_ff, gbc_ff, gbr_ff;
   logic [CB-1:0] count_ff, count_in, rgtot_ff, rgtot_in, gbtot_ff, gbtot_in;
   logic [CB-1:0] prev_ff, prev_in;
   logic [PW-1:0] c_ff, c_in;
   logic [1:0] phase_ff, phase_in;
   logic [IW:0] i_ff, i_in;
   logic [IW-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic fault_ff, fault_in;
   logic rsp_valid_ff, rsp_valid_in;
   rgbhm_pkg::rsp_type rsp_ff, rsp_in;
   logic [AW-1:0] raddr, line_start;
   logic [DW-1:0] rc, rr, gc, gr, n_line, inc_line;
   logic div_start, div_done;
   logic [PW-1:0] dividend, quot;
   logic [CB-1:0] divisor;
   logic [IW-1:0] gcol, pick, walk_res;
   logic req_fire, csr_fire, rg_we, gb_we, query_go, walk_stop;

   assign rc = rgbhm_pkg::clamp_dim(rgc_ff);
   assign rr = rgbhm_pkg::clamp_dim(rgr_ff);
   assign gc = rgbhm_pkg::clamp_dim(gbc_ff);
   assign gr = rgbhm_pkg::clamp_dim(gbr_ff);
   assign gcol = (32'(green_ff) < 32'(gc)) ? green_ff : IW'(gc - DW'(1));

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign csr_fire = csr_valid && csr_ready;
   assign rg_we = req_fire && req_data.kind == rgbhm_pkg::KIND_LOAD_RG
                  && 32'(req_data.table_index) < rgbhm_pkg::DEPTH;
   assign gb_we = req_fire && req_data.kind == rgbhm_pkg::KIND_LOAD_GB
                  && 32'(req_data.table_index) < rgbhm_pkg::DEPTH;
   assign query_go = req_fire && req_data.kind == rgbhm_pkg::KIND_QUERY
                     && req_data.source_count[CB-1:0] != '0;

   assign n_line = (phase_ff == PH_RED) ? rc : ((phase_ff == PH_GREEN) ? rr : gr);
   assign inc_line = (phase_ff == PH_RED) ? DW'(1) : ((phase_ff == PH_BLUE) ? gc : rc);
   assign line_start = (phase_ff == PH_RED) ? AW'(32'(rr - DW'(1)) * 32'(rc)) :
                       ((phase_ff == PH_GREEN) ? AW'(red_ff) : AW'(gcol));
   assign rd_q = (phase_ff == PH_BLUE) ? gb_q : rg_q;
   assign dividend = PW'(rd_q) * PW'(count_ff);
   assign divisor = (phase_ff == PH_BLUE) ? gbtot_ff : rgtot_ff;

   // rd_q holds entry i, prev_ff entry i-1 (already below the count)
   assign pick = ((PW'(rd_q) - c_ff) < (c_ff - PW'(prev_ff))) ? IW'(i_ff)
                 : IW'(i_ff - (IW+1)'(1));
   assign walk_res = (i_ff == '0) ? '0 : pick;
   assign walk_stop = !(PW'(rd_q) < c_ff) || (32'(i_ff) + 1 >= 32'(n_line));

   // read address per state
   always_comb begin
      case (state_ff)
         S_IDLE: raddr = AW'(32'(rr) * 32'(rc) - 1);
         S_TOT1: raddr = AW'(32'(gr) * 32'(gc) - 1);
         S_TOT2: raddr = AW'(32'(rr - DW'(1)) * 32'(rc) - 1);
         S_NEXT: begin
            if (phase_ff == PH_GREEN)
               raddr = AW'(32'(red_ff) + 32'(rr - DW'(1)) * 32'(rc));
            else
               raddr = AW'(32'(gcol) + 32'(gr - DW'(1)) * 32'(gc));
         end
         S_DIV: raddr = line_start;
         S_WALK: raddr = AW'(32'(line_start) + (32'(i_ff) + 1) * 32'(inc_line));
         default: raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rg_we) rg_mem[req_data.table_index[AW-1:0]] <= req_data.table_word[CB-1:0];
      rg_q <= rg_mem[raddr];
   end
   always_ff @(posedge clock) begin
      if (gb_we) gb_mem[req_data.table_index[AW-1:0]] <= req_data.table_word[CB-1:0];
      gb_q <= gb_mem[raddr];
   end

   rgbhm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rgtot_in = rgtot_ff;
      gbtot_in = gbtot_ff;
      prev_in = prev_ff;
      c_in = c_ff;
      phase_in = phase_ff;
      i_in = i_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      fault_in = fault_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (query_go) begin
               count_in = req_data.source_count[CB-1:0];
               phase_in = PH_RED;
               fault_in = 1'b0;
               state_in = S_TOT1;
            end
         end
         S_TOT1: begin
            rgtot_in = rg_q;
            state_in = S_TOT2;
         end
         S_TOT2: begin
            gbtot_in = gb_q;
            if (rgtot_ff == '0 || gb_q == '0) begin
               red_in = '0;
               green_in = '0;
               blue_in = '0;
               fault_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            // scale entry is on rd_q now
            div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               c_in = quot;
               i_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            prev_in = rd_q;
            i_in = i_ff + (IW+1)'(1);
            if (walk_stop) begin
               case (phase_ff)
                  PH_RED: begin
                     red_in = walk_res;
                     phase_in = PH_GREEN;
                     state_in = S_NEXT;
                  end
                  PH_GREEN: begin
                     green_in = walk_res;
                     phase_in = PH_BLUE;
                     state_in = S_NEXT;
                  end
                  default: begin
                     blue_in = walk_res;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_NEXT: state_in = S_SCALE;
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = '{red_index: 8'(red_ff), green_index: 8'(green_ff),
                          blue_index: 8'(blue_ff), divide_fault: fault_ff};
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rgc_ff <= 9'd256;
         rgr_ff <= 9'd256;
         gbc_ff <= 9'd256;
         gbr_ff <= 9'd256;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire) begin
            case (csr_index)
               rgbhm_pkg::REG_RG_COLUMNS: rgc_ff <= csr_data;
               rgbhm_pkg::REG_RG_ROWS:    rgr_ff <= csr_data;
               rgbhm_pkg::REG_GB_COLUMNS: gbc_ff <= csr_data;
               rgbhm_pkg::REG_GB_ROWS:    gbr_ff <= csr_data;
               default: ;
            endcase
         end
      end
      count_ff <= count_in;
      rgtot_ff <= rgtot_in;
      gbtot_ff <= gbtot_in;
      prev_ff <= prev_in;
      c_ff <= c_in;
      phase_ff <= phase_in;
      i_ff <= i_in;
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      fault_ff <= fault_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
